// File: hw/rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared widths, breakpoint tables, register indexes, command codes and stage
// payload types for the descent speed autopilot.
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int BP_COUNT   = 8;
   localparam int IDX_W      = $clog2(BP_COUNT);

   localparam int ALT_W      = 20;
   localparam int SPEED_W    = 18;
   localparam int POWER_W    = 10;
   localparam int TARGET_W   = 16;
   localparam int CMD_W      = 2;

   localparam int EN_W       = 1;
   localparam int CAP_W      = 10;
   localparam int FULL_ALT_W = 17;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam int DELTA_W    = ALT_W + 1;
   localparam int SLOPE_W    = 17;
   localparam int PROD_W     = DELTA_W + SLOPE_W;
   localparam int FRAC_BITS  = 16;
   localparam int SHIFT_W    = PROD_W - FRAC_BITS;
   localparam int SUM_W      = SHIFT_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_CAP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_ALT  = 2'd2;

   localparam logic [EN_W-1:0]       RST_ENABLE    = 1'b0;
   localparam logic [CAP_W-1:0]      RST_POWER_CAP = 10'd890;
   localparam logic [FULL_ALT_W-1:0] RST_FULL_ALT  = 17'd1000;

   localparam logic [POWER_W-1:0] FULL_POWER = 10'd1000;

   localparam logic [CMD_W-1:0] CMD_HOLD     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INCREASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DECREASE = 2'd2;

   localparam logic signed [SUM_W-1:0] TARGET_MIN = -23'sd20000;
   localparam logic signed [SUM_W-1:0] TARGET_MAX = 23'sd0;

   localparam logic [ALT_W-1:0] BP_ALT [BP_COUNT] = '{
      20'd100000, 20'd45000, 20'd27000, 20'd20000,
      20'd10000,  20'd2500,  20'd40,    20'd0
   };

   localparam logic signed [TARGET_W-1:0] BP_SPEED [BP_COUNT] = '{
      -16'sd3500, -16'sd3000, -16'sd2300, -16'sd1800,
      -16'sd1000, -16'sd400,  -16'sd30,   16'sd0
   };

   localparam logic signed [SLOPE_W-1:0] BP_SLOPE [BP_COUNT] = '{
      17'sd0,     -17'sd596,  -17'sd2549, -17'sd4681,
      -17'sd5243, -17'sd5243, -17'sd9857, -17'sd49152
   };

   typedef struct packed {
      logic signed [DELTA_W-1:0]  delta;
      logic signed [SLOPE_W-1:0]  slope;
      logic signed [TARGET_W-1:0] base;
      logic signed [SPEED_W-1:0]  speed;
      logic                       below_cap;
   } dsa_seg_type;

   typedef struct packed {
      logic signed [PROD_W-1:0]   prod;
      logic signed [TARGET_W-1:0] base;
      logic signed [SPEED_W-1:0]  speed;
      logic                       below_cap;
   } dsa_prod_type;

endpackage

// File: hw/rtl/descent_speed_autopilot.sv
// ----------------------------------------------------------------------------
// descent_speed_autopilot
// Requests pass in order through three register stages (segment select,
// slope multiply, target and command) with per-stage valid and ready.
// Throughput: one item per cycle while rsp_ready is high; a low rsp_ready
// can stall the pipeline through the per-stage ready signals.
// Reset: synchronous; empties the pipeline and sets enable 0, power cap 890,
// full power altitude 1000 cm.
// ----------------------------------------------------------------------------
module descent_speed_autopilot
   import dsa_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ALT_W-1:0]            req_altitude_cm,
   input  logic signed [SPEED_W-1:0]   req_speed_cm_s,
   input  logic [POWER_W-1:0]          req_motor_power,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [TARGET_W-1:0]  rsp_target_speed_cm_s,
   output logic [CMD_W-1:0]            rsp_command,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   logic [EN_W-1:0]       enable_ff;
   logic [CAP_W-1:0]      power_cap_ff;
   logic [FULL_ALT_W-1:0] full_alt_ff;

   logic         seg_valid;
   logic         seg_ready;
   dsa_seg_type  seg_data;
   logic         prod_valid;
   logic         prod_ready;
   dsa_prod_type prod_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= RST_ENABLE;
         power_cap_ff <= RST_POWER_CAP;
         full_alt_ff  <= RST_FULL_ALT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_wdata[EN_W-1:0];
            CSR_POWER_CAP: power_cap_ff <= csr_wdata[CAP_W-1:0];
            CSR_FULL_ALT:  full_alt_ff  <= csr_wdata[FULL_ALT_W-1:0];
            default: ;
         endcase
      end
   end

   dsa_seg_select u_seg (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .altitude_cm (req_altitude_cm),
      .speed_cm_s  (req_speed_cm_s),
      .motor_power (req_motor_power),
      .power_cap   (power_cap_ff),
      .full_alt    (full_alt_ff),
      .out_valid   (seg_valid),
      .out_ready   (seg_ready),
      .out_data    (seg_data)
   );

   dsa_slope_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seg_valid),
      .in_ready  (seg_ready),
      .in_data   (seg_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   dsa_decide u_decide (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (prod_valid),
      .in_ready          (prod_ready),
      .in_data           (prod_data),
      .enable            (enable_ff[0]),
      .out_valid         (rsp_valid),
      .out_ready         (rsp_ready),
      .target_speed_cm_s (rsp_target_speed_cm_s),
      .command           (rsp_command)
   );

endmodule

// File: hw/rtl/dsa_seg_select.sv
// ----------------------------------------------------------------------------
// dsa_seg_select
// Stage one: find the segment under the altitude, form the offset from its
// lower breakpoint and pick the power cap.
// ----------------------------------------------------------------------------
module dsa_seg_select
   import dsa_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [ALT_W-1:0]            altitude_cm,
   input  logic signed [SPEED_W-1:0]   speed_cm_s,
   input  logic [POWER_W-1:0]          motor_power,
   input  logic [CAP_W-1:0]            power_cap,
   input  logic [FULL_ALT_W-1:0]       full_alt,
   output logic                        out_valid,
   input  logic                        out_ready,
   output dsa_seg_type                 out_data
);

   logic              valid_ff;
   dsa_seg_type       data_ff;
   dsa_seg_type       data_in;
   logic              hit;
   logic [IDX_W-1:0]  idx;
   logic [POWER_W-1:0] cap;

   always_comb begin
      hit = 1'b0;
      idx = '0;
      for (int k = 1; k < BP_COUNT; k++) begin
         if (!hit && (BP_ALT[k] < altitude_cm)) begin
            hit = 1'b1;
            idx = IDX_W'(k);
         end
      end
   end

   always_comb begin
      cap = (altitude_cm < ALT_W'(full_alt)) ? FULL_POWER : power_cap;
      data_in.speed     = speed_cm_s;
      data_in.below_cap = (motor_power < cap);
      if (hit) begin
         data_in.delta = $signed({1'b0, altitude_cm}) - $signed({1'b0, BP_ALT[idx]});
         data_in.slope = BP_SLOPE[idx];
         data_in.base  = BP_SPEED[idx];
      end else begin
         data_in.delta = '0;
         data_in.slope = '0;
         data_in.base  = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: hw/rtl/dsa_slope_mult.sv
// ----------------------------------------------------------------------------
// dsa_slope_mult
// Stage two: multiply the segment offset by the Q16 segment slope.
// ----------------------------------------------------------------------------
module dsa_slope_mult
   import dsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  dsa_seg_type  in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output dsa_prod_type out_data
);

   logic         valid_ff;
   dsa_prod_type data_ff;
   dsa_prod_type data_in;
   logic signed [PROD_W-1:0] delta_ext;
   logic signed [PROD_W-1:0] slope_ext;

   assign delta_ext = PROD_W'(in_data.delta);
   assign slope_ext = PROD_W'(in_data.slope);

   always_comb begin
      data_in.prod      = delta_ext * slope_ext;
      data_in.base      = in_data.base;
      data_in.speed     = in_data.speed;
      data_in.below_cap = in_data.below_cap;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: hw/rtl/dsa_decide.sv
// ----------------------------------------------------------------------------
// dsa_decide
// Stage three: floor the product, add the breakpoint speed, saturate the
// target and choose the motor command. Holds the result register.
// ----------------------------------------------------------------------------
module dsa_decide
   import dsa_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  dsa_prod_type                in_data,
   input  logic                        enable,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [TARGET_W-1:0]  target_speed_cm_s,
   output logic [CMD_W-1:0]            command
);

   logic                        valid_ff;
   logic signed [TARGET_W-1:0]  target_ff;
   logic [CMD_W-1:0]            command_ff;
   logic signed [TARGET_W-1:0]  target_in;
   logic [CMD_W-1:0]            command_in;
   logic signed [SHIFT_W-1:0]   shifted;
   logic signed [SUM_W-1:0]     sum;
   logic signed [SPEED_W-1:0]   target_ext;

   assign shifted = in_data.prod[PROD_W-1:FRAC_BITS];
   assign sum     = SUM_W'(shifted) + SUM_W'(in_data.base);

   always_comb begin
      if (sum < TARGET_MIN) begin
         target_in = TARGET_W'(TARGET_MIN);
      end else if (sum > TARGET_MAX) begin
         target_in = TARGET_W'(TARGET_MAX);
      end else begin
         target_in = TARGET_W'(sum);
      end
   end

   assign target_ext = SPEED_W'(target_in);

   always_comb begin
      if (!enable) begin
         command_in = CMD_HOLD;
      end else if (in_data.speed < target_ext) begin
         command_in = in_data.below_cap ? CMD_INCREASE : CMD_HOLD;
      end else begin
         command_in = CMD_DECREASE;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         target_ff  <= target_in;
         command_ff <= command_in;
      end
   end

   assign out_valid         = valid_ff;
   assign target_speed_cm_s = target_ff;
   assign command           = command_ff;

endmodule
